// ----- design/gceg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad change event generator package
// Shared types, status and event codes, and pending-vector layout.
// ----------------------------------------------------------------------------
package gceg_pkg;

  localparam int unsigned PadCountDef = 4;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatNoConn = 2'd1;

  // pending vector: down bits, up bits, then one bit per analog/failure event
  localparam int unsigned PendW    = 37;
  localparam int unsigned PendLt   = 32;
  localparam int unsigned PendRt   = 33;
  localparam int unsigned PendLs   = 34;
  localparam int unsigned PendRs   = 35;
  localparam int unsigned PendFail = 36;

  typedef enum logic [2:0] {
    EvDown    = 3'd0,
    EvUp      = 3'd1,
    EvLeftTrg = 3'd2,
    EvRghtTrg = 3'd3,
    EvLeftStk = 3'd4,
    EvRghtStk = 3'd5,
    EvFail    = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic [31:0] packet;
    logic [15:0] buttons;
    logic [15:0] triggers;
    logic [63:0] sticks;
  } pad_state_t;

endpackage

// ----- design/gceg_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report channel
// Valid/ready channel carrying one polled controller report per transaction.
// ----------------------------------------------------------------------------
interface gceg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         pad;
  logic [1:0]         read_status;
  logic [31:0]        packet_number;
  logic [15:0]        buttons;
  logic [7:0]         left_trigger;
  logic [7:0]         right_trigger;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;

  modport source (
    output valid, pad, read_status, packet_number, buttons, left_trigger,
           right_trigger, left_x, left_y, right_x, right_y,
    input  ready
  );

  modport sink (
    input  valid, pad, read_status, packet_number, buttons, left_trigger,
           right_trigger, left_x, left_y, right_x, right_y,
    output ready
  );
endinterface

// ----- design/gceg_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad event channel
// Valid/ready channel carrying one change event per transaction.
// ----------------------------------------------------------------------------
interface gceg_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [1:0]         event_pad;
  logic [15:0]        button_mask;
  logic signed [15:0] value_first;
  logic signed [15:0] value_second;
  logic               last_event;

  modport source (
    output valid, event_kind, event_pad, button_mask, value_first, value_second,
           last_event,
    input  ready
  );

  modport sink (
    input  valid, event_kind, event_pad, button_mask, value_first, value_second,
           last_event,
    output ready
  );
endinterface

// ----- design/gceg_pad_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-pad state store
// Last accepted report of every pad; one read and one write port, reset to zero.
// ----------------------------------------------------------------------------
module gceg_pad_store #(
  parameter int unsigned PAD_COUNT = gceg_pkg::PadCountDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       wr_en_i,
  input  logic [((PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1)-1:0] wr_idx_i,
  input  gceg_pkg::pad_state_t                       wr_data_i,
  input  logic [((PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1)-1:0] rd_idx_i,
  output gceg_pkg::pad_state_t                       rd_data_o
);

  gceg_pkg::pad_state_t mem_q [PAD_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(PAD_COUNT); i++) begin
        mem_q[i] <= '0;
      end
    end else if (wr_en_i && (32'(wr_idx_i) < PAD_COUNT)) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = (32'(rd_idx_i) < PAD_COUNT) ? mem_q[rd_idx_i] : '0;

endmodule

// ----- design/gamepad_change_event_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad change event generator
// A report is registered on acceptance and compared with the stored pad state
// in the check state; its N events (N up to 20: at most 16 button events plus
// 4 analog events) are registered one by one in the emit state, and no new
// report is taken before the last is loaded. Unless the event side holds off, one
// event per cycle leaves through a lowest-set-bit isolate shared by all kinds.
// Reset: asynchronous, clears all pad state to zero and the sequencer to idle.
// ----------------------------------------------------------------------------
module gamepad_change_event_generator_unit #(
  parameter int unsigned PAD_COUNT = gceg_pkg::PadCountDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  gceg_in_if.sink    in_i,
  gceg_out_if.source out_o
);

  localparam int unsigned PadIdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int unsigned PendW   = gceg_pkg::PendW;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StCheck = 3'b010,
    StEmit  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [PendW-1:0]     pend_q, pend_d;
  logic [1:0]           pad_q;
  logic [1:0]           status_q;
  gceg_pkg::pad_state_t item_q;
  gceg_pkg::pad_state_t rd_state;

  logic                 in_acc;
  logic                 pad_ok;
  logic                 fresh;
  logic [15:0]          delta, down, up;
  logic [PendW-1:0]     iso, pend_rest;
  logic                 load_out;

  logic                 out_valid_q;
  gceg_pkg::event_kind_e kind_q, kind_d;
  logic [1:0]           ev_pad_q;
  logic [15:0]          mask_q, mask_d;
  logic [15:0]          first_q, first_d;
  logic [15:0]          second_q, second_d;
  logic                 last_q;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;

  gceg_pad_store #(
    .PAD_COUNT(PAD_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  ((state_q == StCheck) && fresh),
    .wr_idx_i (PadIdxW'(pad_q)),
    .wr_data_i(item_q),
    .rd_idx_i (PadIdxW'(pad_q)),
    .rd_data_o(rd_state)
  );

  assign pad_ok = 32'(pad_q) < PAD_COUNT;
  assign fresh  = pad_ok && (status_q == gceg_pkg::StatOk) &&
                  (item_q.packet > rd_state.packet);
  assign delta  = item_q.buttons ^ rd_state.buttons;
  assign down   = item_q.buttons & delta;
  assign up     = down ^ delta;

  assign iso       = pend_q & (~pend_q + PendW'(1));
  assign pend_rest = pend_q & ~iso;
  assign load_out  = (state_q == StEmit) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (!pad_ok || (status_q == gceg_pkg::StatNoConn)) begin
          pend_d = '0;
        end else if (status_q != gceg_pkg::StatOk) begin
          pend_d = PendW'(1) << gceg_pkg::PendFail;
        end else if (fresh) begin
          pend_d = {1'b0,
                    rd_state.sticks[63:32] != item_q.sticks[63:32],
                    rd_state.sticks[31:0]  != item_q.sticks[31:0],
                    rd_state.triggers[15:8] != item_q.triggers[15:8],
                    rd_state.triggers[7:0]  != item_q.triggers[7:0],
                    up, down};
        end else begin
          pend_d = '0;
        end
        state_d = (pend_d != '0) ? StEmit : StIdle;
      end
      StEmit: begin
        if (load_out) begin
          pend_d = pend_rest;
          if (pend_rest == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
        pend_d  = '0;
      end
    endcase
  end

  always_comb begin
    kind_d   = gceg_pkg::EvFail;
    mask_d   = iso[15:0] | iso[31:16];
    first_d  = '0;
    second_d = '0;
    priority if (|iso[15:0]) begin
      kind_d = gceg_pkg::EvDown;
    end else if (|iso[31:16]) begin
      kind_d = gceg_pkg::EvUp;
    end else if (iso[gceg_pkg::PendLt]) begin
      kind_d  = gceg_pkg::EvLeftTrg;
      first_d = {8'b0, item_q.triggers[7:0]};
    end else if (iso[gceg_pkg::PendRt]) begin
      kind_d  = gceg_pkg::EvRghtTrg;
      first_d = {8'b0, item_q.triggers[15:8]};
    end else if (iso[gceg_pkg::PendLs]) begin
      kind_d   = gceg_pkg::EvLeftStk;
      first_d  = item_q.sticks[15:0];
      second_d = item_q.sticks[31:16];
    end else if (iso[gceg_pkg::PendRs]) begin
      kind_d   = gceg_pkg::EvRghtStk;
      first_d  = item_q.sticks[47:32];
      second_d = item_q.sticks[63:48];
    end else begin
      kind_d = gceg_pkg::EvFail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pad_q           <= in_i.pad;
      status_q        <= in_i.read_status;
      item_q.packet   <= in_i.packet_number;
      item_q.buttons  <= in_i.buttons;
      item_q.triggers <= {in_i.right_trigger, in_i.left_trigger};
      item_q.sticks   <= {in_i.right_y, in_i.right_x, in_i.left_y, in_i.left_x};
    end
    if (load_out) begin
      kind_q   <= kind_d;
      ev_pad_q <= pad_q;
      mask_q   <= mask_d;
      first_q  <= first_d;
      second_q <= second_d;
      last_q   <= (pend_rest == '0);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_kind   = kind_q;
  assign out_o.event_pad    = ev_pad_q;
  assign out_o.button_mask  = mask_q;
  assign out_o.value_first  = first_q;
  assign out_o.value_second = second_q;
  assign out_o.last_event   = last_q;

endmodule

// ----- design/gceg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad change event generator checker
// Port-level properties of the report and event streams, bound to the unit.
// ----------------------------------------------------------------------------
module gceg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  event_kind_i,
  input logic [15:0] button_mask_i,
  input logic [15:0] value_first_i,
  input logic        last_event_i
);

  logic is_button;

  assign is_button = (event_kind_i == gceg_pkg::EvDown) ||
                     (event_kind_i == gceg_pkg::EvUp);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("report taken while previous report still in work");

  a_button_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_button |-> $onehot(button_mask_i))
    else $error("button event mask not one-hot");

  a_analog_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_button |-> (button_mask_i == '0))
    else $error("non-button event carries a button mask");

  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == gceg_pkg::EvFail) |->
      last_event_i && (value_first_i == '0))
    else $error("failure event not a lone final event");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i) &&
      $stable(button_mask_i) && $stable(last_event_i))
    else $error("stalled event changed");

endmodule

bind gamepad_change_event_generator_unit gceg_checker u_gceg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_kind_i (out_o.event_kind),
  .button_mask_i(out_o.button_mask),
  .value_first_i(out_o.value_first),
  .last_event_i (out_o.last_event)
);

// ----- tb/tb_gamepad_change_event_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad change event generator testbench
// Drives polled controller reports into the unit and checks every change
// event against a per-pad predictor kept in a small scoreboard class.
// A directed part covers field extremes, stale and repeated packets, and the
// status codes. A random part follows, made of well-formed report sequences
// with some noise. Random idling is applied on both channels, the event side
// is held off once for a long stretch, and the run drains before it ends.
// ----------------------------------------------------------------------------
module tb_gamepad_change_event_generator_unit;

  localparam int unsigned PAD_NUM      = gceg_pkg::PadCountDef;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [1:0]  StatFail     = 2'd2;
  localparam logic [1:0]  StatSpare    = 2'd3;

  typedef struct packed {
    logic [1:0]  pad;
    logic [1:0]  status;
    logic [31:0] packet;
    logic [15:0] buttons;
    logic [7:0]  lt;
    logic [7:0]  rt;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } report_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  pad;
    logic [15:0] mask;
    logic [15:0] val_first;
    logic [15:0] val_second;
    logic        last;
  } pad_event_t;

  class gamepad_event_scoreboard;
    gceg_pkg::pad_state_t pads [PAD_NUM];
    pad_event_t  expected_q [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned reports;
    int unsigned kind_seen [8];

    function new();
      foreach (pads[i]) pads[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      mismatches = 0;
      checked = 0;
      reports = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void expect_event(gceg_pkg::event_kind_e kind, logic [1:0] pad,
                               logic [15:0] mask, logic [15:0] val_first,
                               logic [15:0] val_second);
      pad_event_t e;
      e.kind       = kind;
      e.pad        = pad;
      e.mask       = mask;
      e.val_first  = val_first;
      e.val_second = val_second;
      e.last       = 1'b0;
      expected_q.push_back(e);
    endfunction

    function void note_report(report_t r);
      gceg_pkg::pad_state_t prev;
      logic [15:0] delta;
      logic [15:0] down;
      logic [15:0] up;
      int unsigned base_n;
      pad_event_t  tail;
      reports++;
      base_n = expected_q.size();
      if (r.pad < PAD_NUM && r.status != gceg_pkg::StatNoConn) begin
        prev = pads[r.pad];
        if (r.status != gceg_pkg::StatOk) begin
          expect_event(gceg_pkg::EvFail, r.pad, '0, '0, '0);
        end else if (r.packet > prev.packet) begin
          delta = r.buttons ^ prev.buttons;
          down  = r.buttons & delta;
          up    = prev.buttons & delta;
          for (int j = 0; j < 16; j++)
            if (down[j]) expect_event(gceg_pkg::EvDown, r.pad, 16'h1 << j, '0, '0);
          for (int j = 0; j < 16; j++)
            if (up[j]) expect_event(gceg_pkg::EvUp, r.pad, 16'h1 << j, '0, '0);
          if (prev.triggers[7:0] != r.lt)
            expect_event(gceg_pkg::EvLeftTrg, r.pad, '0, {8'h00, r.lt}, '0);
          if (prev.triggers[15:8] != r.rt)
            expect_event(gceg_pkg::EvRghtTrg, r.pad, '0, {8'h00, r.rt}, '0);
          if (prev.sticks[31:0] != {r.ly, r.lx})
            expect_event(gceg_pkg::EvLeftStk, r.pad, '0, r.lx, r.ly);
          if (prev.sticks[63:32] != {r.ry, r.rx})
            expect_event(gceg_pkg::EvRghtStk, r.pad, '0, r.rx, r.ry);
          pads[r.pad] = '{packet: r.packet, buttons: r.buttons, triggers: {r.rt, r.lt},
                          sticks: {r.ry, r.rx, r.ly, r.lx}};
        end
      end
      if (expected_q.size() > base_n) begin
        tail = expected_q.pop_back();
        tail.last = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("event %0d %s got %h expected %h", checked, name, got, want));
    endtask

    task check_event(pad_event_t got);
      pad_event_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d pad %0d", got.kind, got.pad));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      kind_seen[want.kind]++;
      check_field("event_kind", got.kind, want.kind);
      check_field("event_pad", got.pad, want.pad);
      check_field("button_mask", got.mask, want.mask);
      check_field("value_first", got.val_first, want.val_first);
      check_field("value_second", got.val_second, want.val_second);
      check_field("last_event", got.last, want.last);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  gceg_in_if  rpt_if ();
  gceg_out_if evt_if ();

  gamepad_change_event_generator_unit #(
    .PAD_COUNT(PAD_NUM)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (rpt_if),
    .out_o (evt_if)
  );

  gamepad_event_scoreboard sb = new();

  bit          src_idle_en;
  bit          sink_stall_en;
  bit          long_hold_req;
  int unsigned stalled_cycles;
  pad_event_t  seen_event;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic report_t mk(logic [1:0] pad, logic [1:0] status, logic [31:0] packet,
                                 logic [15:0] buttons, logic [7:0] lt, logic [7:0] rt,
                                 logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
                                 logic [15:0] ry);
    return '{pad: pad, status: status, packet: packet, buttons: buttons, lt: lt, rt: rt,
             lx: lx, ly: ly, rx: rx, ry: ry};
  endfunction

  function automatic logic [31:0] stick_move(logic [31:0] cur);
    case ($urandom_range(0, 3))
      0: return cur;
      1: return {cur[31:16], 16'($urandom)};
      2: return {16'($urandom), cur[15:0]};
      default: return $urandom;
    endcase
  endfunction

  function automatic report_t next_pad_report(bit well_formed);
    report_t     r;
    gceg_pkg::pad_state_t cur;
    logic [15:0] flips;
    logic [32:0] nxt;
    r.pad = 2'($urandom_range(0, PAD_NUM - 1));
    cur = sb.pads[r.pad];
    if (!well_formed) begin
      r.status  = 2'($urandom_range(0, 3));
      r.packet  = $urandom;
      r.buttons = 16'($urandom);
      r.lt      = 8'($urandom);
      r.rt      = 8'($urandom);
      {r.ly, r.lx} = $urandom;
      {r.ry, r.rx} = $urandom;
      return r;
    end
    case ($urandom_range(0, 19))
      0: r.status = gceg_pkg::StatNoConn;
      1: r.status = StatFail;
      2: r.status = StatSpare;
      default: r.status = gceg_pkg::StatOk;
    endcase
    if ($urandom_range(0, 15) == 0) nxt = {1'b0, cur.packet} + 33'($urandom_range(1, 1 << 20));
    else nxt = {1'b0, cur.packet} + 33'($urandom_range(1, 40));
    r.packet = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
    case ($urandom_range(0, 3))
      0: flips = '0;
      1: flips = 16'h1 << $urandom_range(0, 15);
      2: flips = 16'($urandom) & 16'($urandom);
      default: flips = 16'($urandom);
    endcase
    r.buttons = cur.buttons ^ flips;
    r.lt = $urandom_range(0, 1) ? cur.triggers[7:0] : 8'($urandom);
    r.rt = $urandom_range(0, 1) ? cur.triggers[15:8] : 8'($urandom);
    {r.ly, r.lx} = stick_move(cur.sticks[31:0]);
    {r.ry, r.rx} = stick_move(cur.sticks[63:32]);
    return r;
  endfunction

  task automatic send_report(report_t r);
    rpt_if.valid         <= 1'b1;
    rpt_if.pad           <= r.pad;
    rpt_if.read_status   <= r.status;
    rpt_if.packet_number <= r.packet;
    rpt_if.buttons       <= r.buttons;
    rpt_if.left_trigger  <= r.lt;
    rpt_if.right_trigger <= r.rt;
    rpt_if.left_x        <= r.lx;
    rpt_if.left_y        <= r.ly;
    rpt_if.right_x       <= r.rx;
    rpt_if.right_y       <= r.ry;
    do @(posedge clk_i); while (rpt_if.ready !== 1'b1);
    sb.note_report(r);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      rpt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_batch(int unsigned n, int unsigned noise_pct);
    repeat (n) send_report(next_pad_report($urandom_range(0, 99) >= noise_pct));
  endtask

  // event side: random stalls, or one long hold-off on request
  initial begin
    evt_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        evt_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
        evt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        evt_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
      seen_event.kind       = evt_if.event_kind;
      seen_event.pad        = evt_if.event_pad;
      seen_event.mask       = evt_if.button_mask;
      seen_event.val_first  = evt_if.value_first;
      seen_event.val_second = evt_if.value_second;
      seen_event.last       = evt_if.last_event;
      sb.check_event(seen_event);
    end
  end

  initial begin
    stalled_cycles = 0;
    wait (rst_ni === 1'b1);
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((rpt_if.valid === 1'b1 && rpt_if.ready === 1'b1) ||
          (evt_if.valid === 1'b1 && evt_if.ready === 1'b1))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    rpt_if.valid         <= 1'b0;
    rpt_if.pad           <= '0;
    rpt_if.read_status   <= '0;
    rpt_if.packet_number <= '0;
    rpt_if.buttons       <= '0;
    rpt_if.left_trigger  <= '0;
    rpt_if.right_trigger <= '0;
    rpt_if.left_x        <= '0;
    rpt_if.left_y        <= '0;
    rpt_if.right_x       <= '0;
    rpt_if.right_y       <= '0;
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    long_hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    send_report(mk(0, gceg_pkg::StatOk, 1, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h7FFF));
    send_report(mk(0, gceg_pkg::StatOk, 2, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000));
    send_report(mk(0, gceg_pkg::StatOk, 2, 16'h0001, 8'h11, 8'h22, 16'h0001, 16'h0001,
                   16'h0001, 16'h0001));
    send_report(mk(0, gceg_pkg::StatOk, 1, 16'h0001, 8'h11, 8'h22, 16'h0001, 16'h0001,
                   16'h0001, 16'h0001));
    send_report(mk(0, gceg_pkg::StatOk, 3, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000));
    send_report(mk(1, gceg_pkg::StatNoConn, 5, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF));
    send_report(mk(1, StatFail, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF));
    send_report(mk(2, StatSpare, 7, 16'h1234, 8'h10, 8'h20, 16'h0030, 16'h0040, 16'h0050,
                   16'h0060));
    send_report(mk(1, gceg_pkg::StatOk, 1, 16'h8001, 8'h01, 8'h00, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000));
    send_report(mk(1, gceg_pkg::StatOk, 2, 16'h0001, 8'h01, 8'h80, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000));
    send_report(mk(1, gceg_pkg::StatOk, 3, 16'h0001, 8'h01, 8'h80, 16'h0000, 16'hFFFF,
                   16'h0000, 16'h0000));
    send_report(mk(1, gceg_pkg::StatOk, 4, 16'h0001, 8'h01, 8'h80, 16'h0000, 16'hFFFF,
                   16'h0001, 16'h0000));
    send_report(mk(1, gceg_pkg::StatOk, 5, 16'h5555, 8'h01, 8'h80, 16'h0000, 16'hFFFF,
                   16'h0001, 16'h0000));
    send_report(mk(1, gceg_pkg::StatOk, 6, 16'hAAAA, 8'hFE, 8'h7F, 16'h8000, 16'h7FFF,
                   16'h7FFF, 16'h8000));
    send_report(mk(3, gceg_pkg::StatOk, 0, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF,
                   16'h7FFF, 16'h7FFF));
    send_report(mk(3, gceg_pkg::StatOk, 32'h8000_0000, 16'h0000, 8'h00, 8'h00, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000));
    send_report(mk(2, gceg_pkg::StatOk, 32'h7FFF_FFFF, 16'h00FF, 8'h80, 8'h01, 16'h8000,
                   16'h8000, 16'hFFFF, 16'hFFFF));
    send_report(mk(2, gceg_pkg::StatOk, 32'h7FFF_FFFF, 16'hFF00, 8'h00, 8'h00, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000));
    send_report(mk(2, gceg_pkg::StatOk, 32'hFFFF_0000, 16'hFF00, 8'h80, 8'h01, 16'h8000,
                   16'h8000, 16'hFFFF, 16'hFFFF));

    send_batch(150, 20);

    // hold everything until the event stream has drained
    rpt_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);

    long_hold_req = 1'b1;
    src_idle_en   = 1'b0;
    send_batch(40, 0);

    src_idle_en = 1'b1;
    send_batch(100, 25);

    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    send_batch(90, 20);
    send_report(mk(3, gceg_pkg::StatOk, 32'hFFFF_FFFF, 16'($urandom), 8'($urandom),
                   8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom)));
    send_report(mk(3, gceg_pkg::StatOk, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF,
                   16'h8000, 16'h8000, 16'h7FFF));
    rpt_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d reports on %0d pads and %0d events", sb.reports, PAD_NUM, sb.checked);
    $display("events: %0d down, %0d up, %0d trigger, %0d stick, %0d failure",
             sb.kind_seen[gceg_pkg::EvDown], sb.kind_seen[gceg_pkg::EvUp],
             sb.kind_seen[gceg_pkg::EvLeftTrg] + sb.kind_seen[gceg_pkg::EvRghtTrg],
             sb.kind_seen[gceg_pkg::EvLeftStk] + sb.kind_seen[gceg_pkg::EvRghtStk],
             sb.kind_seen[gceg_pkg::EvFail]);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
